// ===== sv/ird_pkg.sv =====
// Shared types, constants and the digit table for the radix digit converter.
// No dependencies; imported by ird_front, ird_back and the top level.
package ird_pkg;

    localparam int NUMBER_W  = 64;
    localparam int RADIX_W   = 7;
    localparam int SPACE_W   = 7;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 6;
    localparam int MAX_RADIX = 62;
    // quotient bits resolved per divider cycle
    localparam int DIV_BITS  = 8;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADARG = 2'd1,
        ST_EMPTY  = 2'd2
    } status_t;

    // 0-9, A-Z, a-z; anything past the table reads as zero
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] ch;
        dx = {1'b0, d};
        if (d < DIGIT_W'(10))
            ch = CHAR_W'(7'h30) + dx;
        else if (d < DIGIT_W'(36))
            ch = CHAR_W'(7'h37) + dx;
        else if (d < DIGIT_W'(MAX_RADIX))
            ch = CHAR_W'(7'h3D) + dx;
        else
            ch = '0;
        return ch;
    endfunction

endpackage

// ===== sv/ird_front.sv =====
// Front end: takes request words, checks the arguments and works out the digit limit.
// Depends on ird_pkg; feeds ird_cmd_queue.
module ird_front
    import ird_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64,
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1)
)
(
    input  logic                  push,
    output logic                  full,
    input  logic [NUMBER_W-1:0]   number,
    input  logic [RADIX_W-1:0]    radix,
    input  logic [SPACE_W-1:0]    space,
    input  logic                  q_full,
    output logic                  q_push,
    output status_t               cmd_status,
    output logic [VALUE_BITS-1:0] cmd_value,
    output logic [DIGIT_W-1:0]    cmd_radix,
    output logic [CNT_W-1:0]      cmd_limit
);

    logic bad_args;

    assign full   = q_full;
    assign q_push = push && !q_full;

    assign bad_args = (radix == '0) || (radix > RADIX_W'(MAX_RADIX)) || (space == '0);

    always_comb
    begin
        if (bad_args)
            cmd_status = ST_BADARG;
        else if (space == SPACE_W'(1))
            cmd_status = ST_EMPTY;
        else
            cmd_status = ST_OK;
    end

    // limit is space minus one, capped at the stack depth
    always_comb
    begin
        if (space > SPACE_W'(MAX_DIGITS + 1))
            cmd_limit = CNT_W'(MAX_DIGITS);
        else
            cmd_limit = CNT_W'(space - SPACE_W'(1));
    end

    assign cmd_value = number[VALUE_BITS-1:0];
    assign cmd_radix = radix[DIGIT_W-1:0];

endmodule

// ===== sv/ird_cmd_queue.sv =====
// Short command queue between the front end and the conversion engine.
// No package dependencies; generic width and depth.
module ird_cmd_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== sv/ird_back.sv =====
// Conversion engine: serial divider, digit stack and result output register.
// Depends on ird_pkg; fed from ird_cmd_queue.
module ird_back
    import ird_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64,
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    input  status_t               cmd_status,
    input  logic [VALUE_BITS-1:0] cmd_value,
    input  logic [DIGIT_W-1:0]    cmd_radix,
    input  logic [CNT_W-1:0]      cmd_limit,
    input  logic                  pop,
    output logic                  empty,
    output logic [CHAR_W-1:0]     digit_char,
    output logic [1:0]            status,
    output logic                  last
);

    localparam int STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W  = STEPS * DIV_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int REM_W  = DIGIT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_EMIT = 5'b01000,
        S_FLAG = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic [PAD_W-1:0]     div_reg, div_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [DIGIT_W-1:0]   radix_reg, radix_next;
    logic [CNT_W-1:0]     lim_reg, lim_next;
    status_t              flag_reg, flag_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;

    logic [DIGIT_W-1:0]   stack_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]   rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;

    logic                 out_free;
    logic [DIGIT_W-1:0]   rem_step;
    logic [PAD_W-1:0]     quo_step;
    logic                 digit_done;

    assign out_free   = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign digit_char = out_char_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    // one divider cycle: DIV_BITS restoring steps on the narrow remainder
    always_comb
    begin
        logic [REM_W-1:0]    rem_w;
        logic [REM_W-1:0]    trial;
        logic [DIV_BITS-1:0] top_bits;
        logic [DIV_BITS-1:0] quo_bits;
        rem_w    = {1'b0, rem_reg};
        top_bits = div_reg[PAD_W-1 -: DIV_BITS];
        quo_bits = '0;
        for (int b = DIV_BITS - 1; b >= 0; b--)
        begin
            trial = {rem_w[DIGIT_W-1:0], top_bits[b]};
            if (trial >= {1'b0, radix_reg})
            begin
                rem_w       = trial - {1'b0, radix_reg};
                quo_bits[b] = 1'b1;
            end
            else
            begin
                rem_w = trial;
            end
        end
        rem_step = rem_w[DIGIT_W-1:0];
        quo_step = (div_reg << DIV_BITS) | PAD_W'(quo_bits);
    end

    assign digit_done = (cnt_reg + CNT_W'(1) == lim_reg) || (quo_step == '0);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        radix_next      = radix_reg;
        lim_next        = lim_reg;
        flag_next       = flag_reg;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = cnt_reg[AW-1:0];
        mem_raddr       = AW'(cnt_reg - CNT_W'(1));

        // drop the shown word once taken
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_status == ST_OK)
                    begin
                        div_next   = PAD_W'(cmd_value);
                        radix_next = cmd_radix;
                        lim_next   = cmd_limit;
                        rem_next   = '0;
                        step_next  = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        flag_next  = cmd_status;
                        state_next = S_FLAG;
                    end
                end
            end
            S_DIV:
            begin
                div_next = quo_step;
                rem_next = rem_step;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    // remainder is the next digit, low-order first
                    mem_we    = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    step_next = '0;
                    rem_next  = '0;
                    if (digit_done)
                        state_next = S_READ;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = digit_to_char(rd_data_reg);
                    out_status_next = ST_OK;
                    out_last_next   = (cnt_reg == CNT_W'(1));
                    cnt_next        = cnt_reg - CNT_W'(1);
                    state_next      = (cnt_reg == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            S_FLAG:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = '0;
                    out_status_next = flag_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        radix_reg      <= radix_next;
        lim_reg        <= lim_next;
        flag_reg       <= flag_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= rem_step;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= stack_mem[mem_raddr];
    end

    a_flag_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |-> (out_char_reg == '0) && out_last_reg)
        else $error("error or empty word carries a character or lacks last");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < radix_reg))
        else $error("partial remainder not below radix");

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < lim_reg))
        else $error("digit count reached limit while still dividing");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && out_valid_reg && !pop |=> (state_reg == S_EMIT))
        else $error("digit left emit while output word still held");

endmodule

// ===== sv/integer_to_radix_digits.sv =====
// Top level of the radix digit converter: front end, command queue, conversion engine.
// Depends on ird_pkg, ird_front, ird_cmd_queue and ird_back.
//
//  channel   direction  handshake         payload
//  request   in         push / full       number, radix, space
//  result    out        pop / empty       digit_char, status, last
//
// A conversion runs each digit through the shared divider, which resolves 8 quotient
// bits a cycle, then pops the stack one digit at a time through a read state and an
// emit state that waits while the result port is stalled; an error or empty word is
// shown from the flag state instead.
// Reset clears control state only; the digit stack needs no clearing pass.
// A stalled result port holds the engine; the two-entry queue keeps accepting requests until it is full.
module integer_to_radix_digits
    import ird_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [NUMBER_W-1:0] number,
    input  logic [RADIX_W-1:0]  radix,
    input  logic [SPACE_W-1:0]  space,
    input  logic                pop,
    output logic                empty,
    output logic [CHAR_W-1:0]   digit_char,
    output logic [1:0]          status,
    output logic                last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int CMD_W = 2 + VALUE_BITS + DIGIT_W + CNT_W;

    status_t               f_status;
    logic [VALUE_BITS-1:0] f_value;
    logic [DIGIT_W-1:0]    f_radix;
    logic [CNT_W-1:0]      f_limit;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    logic [CMD_W-1:0]      q_din;
    logic [CMD_W-1:0]      q_dout;

    ird_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .push       (push),
        .full       (full),
        .number     (number),
        .radix      (radix),
        .space      (space),
        .q_full     (q_full),
        .q_push     (q_push),
        .cmd_status (f_status),
        .cmd_value  (f_value),
        .cmd_radix  (f_radix),
        .cmd_limit  (f_limit)
    );

    assign q_din = {f_status, f_value, f_radix, f_limit};

    ird_cmd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_dout)
    );

    ird_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (q_empty),
        .cmd_pop    (q_pop),
        .cmd_status (status_t'(q_dout[CMD_W-1 -: 2])),
        .cmd_value  (q_dout[CMD_W-3 -: VALUE_BITS]),
        .cmd_radix  (q_dout[CNT_W +: DIGIT_W]),
        .cmd_limit  (q_dout[CNT_W-1:0]),
        .pop        (pop),
        .empty      (empty),
        .digit_char (digit_char),
        .status     (status),
        .last       (last)
    );

endmodule
